>>> hdl/hid_keyboard_report_to_ascii_top_assert.svh
// Assertion macros for the keyboard report translator checker.
`ifndef HID_KEYBOARD_REPORT_TO_ASCII_TOP_ASSERT_SVH
`define HID_KEYBOARD_REPORT_TO_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HKRA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyboard translator check failed");

// Next-cycle implication, disabled during reset.
`define HKRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyboard translator check failed");

`endif

>>> hdl/hkra_pkg.sv
// Types, constants and lookup tables for the keyboard report translator.
package hkra_pkg;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] key_code;
  } hkra_in_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       led_valid;
    logic [1:0] led_bits;
  } hkra_out_t;

  typedef struct packed {
    logic [7:0] previous_key;
    logic [1:0] lock_leds;
  } hkra_state_t;

  localparam logic [7:0] MOD_CTRL  = 8'h11;
  localparam logic [7:0] MOD_SHIFT = 8'h22;
  localparam logic [7:0] MOD_ALTGR = 8'h40;

  localparam logic [1:0] LED_NUM   = 2'b01;
  localparam logic [1:0] LED_CAPS  = 2'b10;
  localparam logic [1:0] LED_RESET = LED_NUM;

  localparam logic [7:0] KEY_A        = 8'h04;
  localparam logic [7:0] KEY_Q        = 8'h14;
  localparam logic [7:0] KEY_Y        = 8'h1c;
  localparam logic [7:0] KEY_Z        = 8'h1d;
  localparam logic [7:0] KEY_1        = 8'h1e;
  localparam logic [7:0] KEY_0        = 8'h27;
  localparam logic [7:0] KEY_ENTER    = 8'h28;
  localparam logic [7:0] KEY_SPACE    = 8'h2c;
  localparam logic [7:0] KEY_MINUS    = 8'h2d;
  localparam logic [7:0] KEY_SLASH    = 8'h38;
  localparam logic [7:0] KEY_CAPSLOCK = 8'h39;
  localparam logic [7:0] KEY_NUMLOCK  = 8'h53;
  localparam logic [7:0] KEY_KP_DIV   = 8'h54;
  localparam logic [7:0] KEY_KP_DOT   = 8'h63;
  localparam logic [7:0] KEY_NONUS    = 8'h64;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_AT = 8'h40;
  localparam logic [7:0] CHAR_LT = 8'h3c;
  localparam logic [7:0] CHAR_GT = 8'h3e;
  localparam logic [7:0] CHAR_BAR = 8'h7c;

  localparam logic [7:0] LETTER_PLAIN_OFS = 8'h5d;
  localparam logic [7:0] LETTER_UPPER_OFS = 8'h3d;
  localparam logic [7:0] LETTER_CTRL_OFS  = 8'h03;

  localparam logic [1:0] DIGIT_PLAIN = 2'd0;
  localparam logic [1:0] DIGIT_SHIFT = 2'd1;
  localparam logic [1:0] DIGIT_ALTGR = 2'd2;

  function automatic logic [7:0] digit_char(input logic [3:0] idx, input logic [1:0] col);
    logic [7:0] c;
    c = 8'h00;
    case (col)
      DIGIT_PLAIN: begin
        case (idx)
          4'd0: c = 8'h31;
          4'd1: c = 8'h32;
          4'd2: c = 8'h33;
          4'd3: c = 8'h34;
          4'd4: c = 8'h35;
          4'd5: c = 8'h36;
          4'd6: c = 8'h37;
          4'd7: c = 8'h38;
          4'd8: c = 8'h39;
          4'd9: c = 8'h30;
          default: c = 8'h00;
        endcase
      end
      DIGIT_SHIFT: begin
        case (idx)
          4'd0: c = 8'h21;
          4'd1: c = 8'h22;
          4'd2: c = 8'ha7;
          4'd3: c = 8'h24;
          4'd4: c = 8'h25;
          4'd5: c = 8'h26;
          4'd6: c = 8'h2f;
          4'd7: c = 8'h28;
          4'd8: c = 8'h29;
          4'd9: c = 8'h3d;
          default: c = 8'h00;
        endcase
      end
      DIGIT_ALTGR: begin
        case (idx)
          4'd0: c = 8'h31;
          4'd1: c = 8'h32;
          4'd2: c = 8'h33;
          4'd3: c = 8'h34;
          4'd4: c = 8'h35;
          4'd5: c = 8'h36;
          4'd6: c = 8'h7b;
          4'd7: c = 8'h5b;
          4'd8: c = 8'h5d;
          4'd9: c = 8'h7d;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ctl_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h0d;
      3'd1: c = 8'h1b;
      3'd2: c = 8'h08;
      3'd3: c = 8'h09;
      3'd4: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] punct_char(input logic [3:0] idx, input logic shift);
    logic [7:0] c;
    case (idx)
      4'd0:  c = shift ? 8'h3f : 8'hdf;
      4'd1:  c = shift ? 8'hb4 : 8'h60;
      4'd2:  c = shift ? 8'hdc : 8'hfc;
      4'd3:  c = shift ? 8'h2a : 8'h2b;
      4'd5:  c = shift ? 8'h27 : 8'h23;
      4'd6:  c = shift ? 8'hd6 : 8'hf6;
      4'd7:  c = shift ? 8'hc4 : 8'he4;
      4'd8:  c = shift ? 8'hb0 : 8'h5e;
      4'd9:  c = shift ? 8'h3b : 8'h2c;
      4'd10: c = shift ? 8'h3a : 8'h2e;
      4'd11: c = shift ? 8'h5f : 8'h2d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pad_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:  c = 8'h2f;
      4'd1:  c = 8'h2a;
      4'd2:  c = 8'h2d;
      4'd3:  c = 8'h2b;
      4'd4:  c = 8'h0d;
      4'd5:  c = 8'h31;
      4'd6:  c = 8'h32;
      4'd7:  c = 8'h33;
      4'd8:  c = 8'h34;
      4'd9:  c = 8'h35;
      4'd10: c = 8'h36;
      4'd11: c = 8'h37;
      4'd12: c = 8'h38;
      4'd13: c = 8'h39;
      4'd14: c = 8'h30;
      4'd15: c = 8'h2c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/hkra_xlate.sv
// Combinational translation of one keyboard report and the next lock and key state.
module hkra_xlate (
  input  hkra_pkg::hkra_in_t    item,
  input  hkra_pkg::hkra_state_t state,
  input  logic                  newline_translate,
  output hkra_pkg::hkra_out_t   result,
  output hkra_pkg::hkra_state_t state_next
);
  import hkra_pkg::*;

  logic [7:0] ch;
  logic [7:0] k;
  logic [7:0] ofs;
  logic [1:0] col;
  logic       shift;
  logic       ctrl;
  logic       altgr;
  logic       led_evt;

  assign shift = |(item.modifier & MOD_SHIFT);
  assign ctrl  = |(item.modifier & MOD_CTRL);
  assign altgr = |(item.modifier & MOD_ALTGR);

  always_comb begin
    ch         = 8'h00;
    k          = item.key_code;
    ofs        = 8'h00;
    col        = DIGIT_PLAIN;
    led_evt    = 1'b0;
    state_next = state;
    if (item.key_code != state.previous_key) begin
      state_next.previous_key = item.key_code;
      case (item.key_code) inside
        [KEY_A:KEY_Z]: begin
          if (item.key_code == KEY_Y) begin
            k = KEY_Z;
          end else if (item.key_code == KEY_Z) begin
            k = KEY_Y;
          end
          if (ctrl) begin
            ch = k - LETTER_CTRL_OFS;
          end else begin
            ch = (shift ^ |(state.lock_leds & LED_CAPS)) ? k + LETTER_UPPER_OFS
                                                       : k + LETTER_PLAIN_OFS;
            if (k == KEY_Q && altgr) begin
              ch = CHAR_AT;
            end
          end
        end
        [KEY_1:KEY_0]: begin
          ofs = item.key_code - KEY_1;
          col = altgr ? DIGIT_ALTGR : (shift ? DIGIT_SHIFT : DIGIT_PLAIN);
          ch  = digit_char(ofs[3:0], col);
        end
        [KEY_ENTER:KEY_SPACE]: begin
          ofs = item.key_code - KEY_ENTER;
          ch  = ctl_char(ofs[2:0]);
        end
        [KEY_MINUS:KEY_SLASH]: begin
          ofs = item.key_code - KEY_MINUS;
          ch  = punct_char(ofs[3:0], shift);
        end
        KEY_CAPSLOCK: begin
          state_next.lock_leds = state.lock_leds ^ LED_CAPS;
          led_evt = 1'b1;
        end
        KEY_NUMLOCK: begin
          state_next.lock_leds = state.lock_leds ^ LED_NUM;
          led_evt = 1'b1;
        end
        [KEY_KP_DIV:KEY_KP_DOT]: begin
          ofs = item.key_code - KEY_KP_DIV;
          ch  = pad_char(ofs[3:0]);
        end
        KEY_NONUS: begin
          ch = altgr ? CHAR_BAR : (shift ? CHAR_GT : CHAR_LT);
        end
        default: ch = 8'h00;
      endcase
      if (ch[7]) begin
        ch = 8'h00;
      end
      if (ch == CHAR_CR && newline_translate) begin
        ch = CHAR_LF;
      end
    end
    result.char_valid = (ch != 8'h00);
    result.char_code  = ch[6:0];
    result.led_valid  = led_evt;
    result.led_bits   = led_evt ? state_next.lock_leds : 2'b00;
  end

endmodule

>>> hdl/hid_keyboard_report_to_ascii_top.sv
// A report accepted into the input register is translated and moves into the result register
// once that register is empty or its result is taken, and is presented from there.
// Throughput: one report per cycle while out_ready is high; input and result registers each
// hold one transfer. Every accepted report gives exactly one result transfer.
// Reset (synchronous, active high) empties both registers, clears the last key,
// sets NumLock on and CapsLock off, and clears newline translation.
module hid_keyboard_report_to_ascii_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hkra_pkg::hkra_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hkra_pkg::hkra_out_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_data
);
  import hkra_pkg::*;

  logic        in_full;
  hkra_in_t    in_reg;
  logic        out_full;
  hkra_out_t   out_reg;
  hkra_state_t state;
  hkra_state_t state_next;
  hkra_out_t   result;
  logic        newline_translate;
  logic        advance;

  assign advance   = in_full && (!out_full || out_ready);
  assign in_ready  = !in_full || advance;
  assign out_valid = out_full;
  assign out_data  = out_reg;

  hkra_xlate u_xlate (
    .item              (in_reg),
    .state             (state),
    .newline_translate (newline_translate),
    .result            (result),
    .state_next        (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full                <= 1'b0;
      out_full               <= 1'b0;
      state.previous_key     <= 8'h00;
      state.lock_leds        <= LED_RESET;
      newline_translate      <= 1'b0;
    end else begin
      if (cfg_we) begin
        newline_translate <= cfg_data;
      end
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_full <= 1'b1;
        state    <= state_next;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
    if (advance) begin
      out_reg <= result;
    end
  end

endmodule

>>> hdl/hkra_checker.sv
// Port-level checks on the keyboard translator results, bound to the top level.
`include "hid_keyboard_report_to_ascii_top_assert.svh"

module hkra_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input hkra_pkg::hkra_out_t out_data
);
  import hkra_pkg::*;

  `HKRA_ASSERT_NOW(a_char_code_iff_valid, clk, rst, out_valid, out_data.char_valid == (out_data.char_code != 7'h00))
  `HKRA_ASSERT_NOW(a_led_bits_idle_zero, clk, rst, out_valid && !out_data.led_valid, out_data.led_bits == 2'b00)
  `HKRA_ASSERT_NOW(a_char_or_led, clk, rst, out_valid, !(out_data.char_valid && out_data.led_valid))
  `HKRA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind hid_keyboard_report_to_ascii_top hkra_checker u_hkra_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
